// File: hdl/tcpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_pkg: shared constants and types of the execute unit
// Opcodes, jump conditions, compare flag codes, operand source codes, address base and default sizes.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int DataWordsDefault = 256;
  localparam int RegCountDefault  = 16;
  localparam logic [31:0] AddrBase = 32'd16384;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0, OP_MOVE = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL  = 4'd4, OP_DIV  = 4'd5, OP_AND = 4'd6, OP_OR  = 4'd7,
    OP_NOT  = 4'd8, OP_CMP  = 4'd9, OP_JUMP = 4'd10, OP_IN = 4'd11,
    OP_OUT  = 4'd12
  } opcode_t;

  localparam logic [1:0] FlagEq = 2'b00;
  localparam logic [1:0] FlagGt = 2'b01;
  localparam logic [1:0] FlagLt = 2'b11;

  localparam logic [3:0] CondAlways = 4'd0;
  localparam logic [3:0] CondEq     = 4'd1;
  localparam logic [3:0] CondGt     = 4'd2;
  localparam logic [3:0] CondLt     = 4'd3;
  localparam logic [3:0] SrcImm     = 4'd0;
  localparam logic [3:0] SrcStoreHi = 4'd4;

endpackage
`default_nettype wire

// File: hdl/toy_cpu_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit: sequential execute stage of a small register machine
// Runs one decoded instruction per item against a register file, compare
// flag, byte program counter and a data memory cleared after reset.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)                          | tuser
//  s_axis  | in  | command[3:0] dst_reg[7:4] src_reg[11:8] immediate[27:12]|
//          |     | in_value[59:28], zero fill to 64 bits                  | -
//  m_axis  | out | next_ip[15:0] cmp_flag[17:16] out_value[49:18]          |
//          |     | halted[50] instr_code[62:51], zero fill to 64 bits     | out_valid,
//          |     |                                                        | div_by_zero
//
// After reset a clearing pass zeroes all DATA_WORDS memory words, one word a
// cycle; no item is taken meanwhile. An item steps through accept, operand
// read, execute, write back and result; mul, and div with a nonzero divisor,
// also iterate in the shared shift/add unit before write back, unless halted.
// s_axis_tready stays low while an item is in flight or its result waits on a
// stalled m_axis.
module toy_cpu_execute_unit
  import tcpu_pkg::*;
#(
  parameter int DATA_WORDS = DataWordsDefault,
  parameter int REG_COUNT  = RegCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // command, dst_reg, src_reg, immediate, in_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // next_ip, cmp_flag, out_value, halted, instr_code
  output logic [1:0]       m_axis_tuser    // out_valid, div_by_zero
);

  localparam int AW = $clog2(DATA_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_OPND, S_EXEC, S_ITER, S_WB, S_OUT
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;

  logic [31:0] mem [DATA_WORDS];
  logic [31:0] mem_rdata;
  logic [31:0] regs [16];

  // latched item
  logic [3:0]  cmd, dst, src;
  logic [31:0] imm, inv;
  logic [31:0] a, op;       // dst value and operand
  logic [AW-1:0] op_addr, a_addr;

  logic [15:0] pc;
  logic [1:0]  flag;
  logic        halt;

  // shared shift/add unit
  logic [31:0] acc, shreg, divisor;
  logic [5:0]  iter;
  logic        neg_q;

  logic        out_v, dz;
  logic [31:0] out_val;

  function automatic logic [AW-1:0] mem_idx(input logic [31:0] v);
    logic [31:0] d;
    logic [31:0] h;
    d = v - AddrBase;
    h = {d[31], d[31:1]};
    return h[AW-1:0];
  endfunction

  function automatic logic [31:0] rd(input logic [31:0] r [16], input logic [3:0] i);
    return (32'(i) < 32'(REG_COUNT)) ? r[i] : 32'd0;
  endfunction

  logic [31:0] a_rd, s_rd;
  assign a_rd = rd(regs, s_axis_tdata[7:4]);
  assign s_rd = rd(regs, s_axis_tdata[11:8]);

  logic [32:0] sub_try;
  assign sub_try = {acc, shreg[31]} - {1'b0, divisor};

  assign s_axis_tready = (state == S_IDLE);

  logic jump_take;
  always_comb begin
    case (src)
      CondAlways: jump_take = 1'b1;
      CondEq:     jump_take = (flag == FlagEq);
      CondGt:     jump_take = (flag == FlagGt);
      CondLt:     jump_take = (flag == FlagLt);
      default:    jump_take = 1'b0;
    endcase
  end

  // memory: one write port, registered read
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rdata <= mem[mem_ra];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 32'd0;
    mem_ra = op_addr;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WB && !halt) begin
      if (cmd == OP_MOVE && src != SrcImm && src <= SrcStoreHi) begin
        mem_we = 1'b1; mem_wa = a_addr; mem_wd = rd(regs, src);
      end else if (cmd == OP_NOT && src != SrcImm) begin
        mem_we = 1'b1; mem_wa = op_addr; mem_wd = {31'd0, op == 32'd0};
      end
    end
  end

  logic        rw_en;
  logic [31:0] rw_val;
  always_comb begin
    rw_en = 1'b1;
    rw_val = acc;
    case (opcode_t'(cmd))
      OP_MOVE: begin
        rw_en = (src == SrcImm) || (src > SrcStoreHi);
        rw_val = op;
      end
      OP_ADD:  rw_val = a + op;
      OP_SUB:  rw_val = a - op;
      OP_MUL:  rw_val = acc;
      OP_DIV: begin
        rw_en = !dz;
        rw_val = neg_q ? (32'd0 - shreg) : shreg;
      end
      OP_AND:  rw_val = {31'd0, a != 0 && op != 0};
      OP_OR:   rw_val = {31'd0, a != 0 || op != 0};
      OP_NOT: begin
        rw_en = (src == SrcImm);
        rw_val = {31'd0, a == 0};
      end
      OP_IN:   rw_val = inv;
      default: rw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      pc <= '0;
      flag <= FlagEq;
      halt <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) regs[i] <= 32'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == 32'(DATA_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[3:0];
          dst <= s_axis_tdata[7:4];
          src <= s_axis_tdata[11:8];
          imm <= {{16{s_axis_tdata[27]}}, s_axis_tdata[27:12]};
          inv <= s_axis_tdata[59:28];
          a <= a_rd;
          a_addr <= mem_idx(a_rd);
          op_addr <= mem_idx(s_rd);
          dz <= 1'b0;
          out_v <= 1'b0;
          out_val <= 32'd0;
          state <= S_OPND;
        end
        S_OPND: state <= S_EXEC;   // memory read in flight
        S_EXEC: begin
          op <= (src == SrcImm) ? imm : mem_rdata;
          state <= S_WB;
          if (!halt) begin
            if (cmd == OP_MUL || cmd == OP_DIV) begin
              logic [31:0] o;
              o = (src == SrcImm) ? imm : mem_rdata;
              iter <= 6'd0;
              acc <= 32'd0;
              if (cmd == OP_MUL) begin
                shreg <= a;
                divisor <= o;
                state <= S_ITER;
              end else if (o == 32'd0) begin
                dz <= 1'b1;
              end else begin
                shreg <= a[31] ? 32'd0 - a : a;
                divisor <= o[31] ? 32'd0 - o : o;
                neg_q <= a[31] ^ o[31];
                state <= S_ITER;
              end
            end
          end
        end
        S_ITER: begin
          // one bit a cycle: shift-add multiply or restoring divide
          iter <= iter + 1'b1;
          if (cmd == OP_MUL) begin
            acc <= (acc << 1) + (shreg[31] ? divisor : 32'd0);
            shreg <= shreg << 1;
          end else begin
            if (!sub_try[32]) begin
              acc <= sub_try[31:0];
              shreg <= {shreg[30:0], 1'b1};
            end else begin
              acc <= {acc[30:0], shreg[31]};
              shreg <= {shreg[30:0], 1'b0};
            end
          end
          if (iter == 6'd31) state <= S_WB;
        end
        S_WB: begin
          if (!halt) begin
            if (rw_en && 32'(dst) < 32'(REG_COUNT)) regs[dst] <= rw_val;
            if (cmd == OP_HALT) halt <= 1'b1;
            if (cmd == OP_CMP)
              flag <= ($signed(a) > $signed(op)) ? FlagGt :
                      (a == op) ? FlagEq : FlagLt;
            if (cmd == OP_OUT) begin
              out_v <= 1'b1;
              out_val <= a;
            end
            pc <= pc + ((cmd == OP_JUMP && jump_take) ? imm[15:0] : 16'd4);
          end
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, cmd, dst, src, halt, out_val, flag, pc};
  assign m_axis_tuser = {dz, out_v};

endmodule
`default_nettype wire

// File: hdl/tcpu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_checker: port-level checks of the execute unit
// Watches handshakes, result timing and out_value against out_valid.
// ----------------------------------------------------------------------------
module tcpu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // result waits: data holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // never take an item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // accepted item gives no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // out_value is zero without out_valid
  a_outz: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[49:18] == 32'd0)
    else $error("out_value set without out_valid");

endmodule

bind toy_cpu_execute_unit tcpu_checker u_tcpu_checker (.*);
`default_nettype wire
